// ===== src/assert_macros.svh =====
// Assertion helpers used by the detector unit.
// Every check runs on the rising edge of clk and is held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define MWD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cons holds at the next clock edge whenever ante holds.
`define MWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mwd_pkg.sv =====
package mwd_pkg;

	// Width of the size registers and of the reported coordinates
	localparam int unsigned CFG_W     = 11;
	localparam int unsigned COORD_W   = 10;
	localparam int unsigned MIN_SIZE  = 3;
	localparam int unsigned NUM_CELLS = 3;

	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

	// Configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Result kinds
	localparam logic KIND_ENDING      = 1'b0;
	localparam logic KIND_BIFURCATION = 1'b1;

	// One window column: bit 0 top, bit 1 middle, bit 2 bottom
	typedef logic [2:0] wcol_t;

	// Line store word: bit 0 upper row, bit 1 middle row
	typedef struct packed {
		logic mid;
		logic up;
	} lstore_t;

	// Ones in the eight neighbors of the window center
	function automatic logic [3:0] ones8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, v[i]};
		end
		return n;
	endfunction

endpackage

// ===== src/mwd_ram.sv =====
module mwd_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Registered read, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

// ===== src/mwd_win_cell.sv =====
module mwd_win_cell
	import mwd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift_en,
	input  wcol_t col_in,
	output wcol_t col_q
);

	// One window column, takes its neighbor's column on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

endmodule

// ===== src/minutia_window_detector_unit.sv =====
// Minutia window detector.
// Input channel: one binary pixel per beat (in_valid, in_stall, pixel), raster order.
// Output channel: one beat per minutia found (out_valid, out_stall, minutia_kind, col, row);
// kind 0 is a ridge ending (center set, one neighbor set), 1 a bifurcation (three set).
// Border pixels never produce a beat.
// Config port: cfg_we writes cfg_wdata into image_width (index 0) or image_height
// (index 1); other indexes are ignored. Sizes are clamped to 3..MAX_WIDTH / MAX_HEIGHT.
// Throughput: one pixel per cycle while the output is not stalled; the line store
// RAM is read at acceptance and written back when the pixel leaves stage 1.
// Result path: the pixel completing a window is held in stage 1, and its minutia
// is registered into the output register when stage 1 advances.
// Stall: a pending result sits in the output register; one more pixel is taken into
// stage 1, after which in_stall rises until the result is taken.
// Reset: counters, window and size registers go to their defaults (1024 x 1024).
// The line stores are not cleared; they are fully rewritten by the first two rows.
`include "assert_macros.svh"

module minutia_window_detector_unit
	import mwd_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               pixel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               minutia_kind,
	output logic [COORD_W-1:0] col,
	output logic [COORD_W-1:0] row
);

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned RW   = $clog2(MAX_HEIGHT);
	localparam int unsigned WSW0 = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HSW0 = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned SW   = (WSW0 > HSW0) ? ((WSW0 > CFG_W) ? WSW0 : CFG_W)
	                                             : ((HSW0 > CFG_W) ? HSW0 : CFG_W);

	logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
	logic [SW-1:0]    eff_w, eff_h, ext_w, ext_h;
	logic [CW-1:0]    c_q, c_s1;
	logic [RW-1:0]    r_q, r_s1;
	logic             px_s1;
	logic             s1_valid_q;
	logic             accept, out_free, s1_go;
	lstore_t          rd_word, wr_word;
	wcol_t            new_col;
	wcol_t            cell_q [NUM_CELLS];
	wcol_t            cell_in [NUM_CELLS];
	logic [3:0]       nbr_cnt;
	logic             inside_win, hit;
	logic [SW-1:0]    c_ext, r_ext, col_m1, row_m1;

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= SIZE_RESET;
			cfg_h_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_w_q <= cfg_wdata;
				REG_IMAGE_HEIGHT: cfg_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective sizes, clamped
	always_comb begin
		ext_w = SW'(cfg_w_q);
		ext_h = SW'(cfg_h_q);
		if (ext_w < SW'(MIN_SIZE)) begin
			eff_w = SW'(MIN_SIZE);
		end else if (ext_w > SW'(MAX_WIDTH)) begin
			eff_w = SW'(MAX_WIDTH);
		end else begin
			eff_w = ext_w;
		end
		if (ext_h < SW'(MIN_SIZE)) begin
			eff_h = SW'(MIN_SIZE);
		end else if (ext_h > SW'(MAX_HEIGHT)) begin
			eff_h = SW'(MAX_HEIGHT);
		end else begin
			eff_h = ext_h;
		end
	end

	// Handshake
	assign out_free = !out_valid || !out_stall;
	assign s1_go    = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign accept   = in_valid && !in_stall;

	// Raster counters, advance on each accepted pixel
	assign c_ext = SW'(c_q);
	assign r_ext = SW'(r_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (accept) begin
			if (c_ext + SW'(1) >= eff_w) begin
				c_q <= '0;
				if (r_ext + SW'(1) >= eff_h) begin
					r_q <= '0;
				end else begin
					r_q <= r_q + 1'b1;
				end
			end else begin
				c_q <= c_q + 1'b1;
			end
		end
	end

	// Stage 1: pixel and position, line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= pixel;
			c_s1  <= c_q;
			r_s1  <= r_q;
		end
	end

	// Line stores: upper and middle rows share one word
	assign wr_word.up  = rd_word.mid;
	assign wr_word.mid = px_s1;

	mwd_ram #(
		.WIDTH($bits(lstore_t)),
		.DEPTH(MAX_WIDTH)
	) u_lstore (
		.clk  (clk),
		.re   (accept),
		.raddr(c_q),
		.rdata(rd_word),
		.we   (s1_go),
		.waddr(c_s1),
		.wdata(wr_word)
	);

	// Window: chain of column cells, newest at the top index
	assign new_col = {px_s1, rd_word.mid, rd_word.up};

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		if (i == NUM_CELLS - 1) begin : g_head
			assign cell_in[i] = new_col;
		end else begin : g_link
			assign cell_in[i] = cell_q[i+1];
		end
		mwd_win_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(s1_go),
			.col_in  (cell_in[i]),
			.col_q   (cell_q[i])
		);
	end

	// Detection on the window after this shift
	assign nbr_cnt    = ones8({new_col, cell_q[2][2], cell_q[2][0], cell_q[1]});
	assign inside_win = (c_s1 >= CW'(2)) && (r_s1 >= RW'(2))
	                 && (SW'(c_s1) < eff_w) && (SW'(r_s1) < eff_h);
	assign hit        = inside_win && cell_q[2][1]
	                 && ((nbr_cnt == 4'd1) || (nbr_cnt == 4'd3));
	assign col_m1     = SW'(c_s1) - SW'(1);
	assign row_m1     = SW'(r_s1) - SW'(1);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= s1_go && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && hit) begin
			minutia_kind <= (nbr_cnt == 4'd3) ? KIND_BIFURCATION : KIND_ENDING;
			col          <= col_m1[COORD_W-1:0];
			row          <= row_m1[COORD_W-1:0];
		end
	end

	// Checks
	`MWD_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall), "input stalled without a held result")
	`MWD_ASSERT_NEXT(a_accept_fill, accept, s1_valid_q, "accepted pixel lost before stage 1")
	`MWD_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_go, s1_valid_q && $stable(c_s1) && $stable(px_s1), "stage 1 changed while held")

endmodule
